/* rtl/rhsv_pkg.sv */
`timescale 1ns / 1ps
package rhsv_pkg;

	localparam int CH_W      = 8;
	localparam int SAT_REM_W = 2 * CH_W;
	localparam int HUE_Q_W   = 6;
	localparam int HUE_REM_W = 14;

	localparam logic [CH_W-1:0]    HUE_BASE_RED   = 8'd0;
	localparam logic [CH_W-1:0]    HUE_BASE_GREEN = 8'd85;
	localparam logic [CH_W-1:0]    HUE_BASE_BLUE  = 8'd171;
	localparam logic [HUE_Q_W-1:0] HUE_STEP       = 6'd43;

	typedef struct packed {
		logic [CH_W-1:0]      mx;
		logic [CH_W-1:0]      rng;
		logic [SAT_REM_W-1:0] sat_rem;
		logic [CH_W-1:0]      sat_q;
		logic [HUE_REM_W-1:0] hue_rem;
		logic [HUE_Q_W-1:0]   hue_q;
		logic                 neg;
		logic [CH_W-1:0]      base;
		logic                 black;
		logic                 grey;
	} rhsv_pay_t;

endpackage

/* rtl/rgb_to_hsv_8bit.sv */
`timescale 1ns / 1ps
// RGB to HSV, 8 bits per channel. Takes one pixel per clock while the output side is
// not stalled. The two restoring dividers (saturation and hue) resolve two quotient
// bits per pipeline stage, saturation over four stages and hue over the first three,
// behind one stage of max/min/sector logic and ahead of one output stage. A stalled
// output holds the pipeline; bubbles close up.
module rgb_to_hsv_8bit import rhsv_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [CH_W-1:0] red,
	input  logic [CH_W-1:0] green,
	input  logic [CH_W-1:0] blue,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [CH_W-1:0] hue,
	output logic [CH_W-1:0] saturation,
	output logic [CH_W-1:0] brightness
);

	localparam int NDIV = 4;

	logic [NDIV+1:0] vld_q;
	logic [NDIV+1:0] en;

	rhsv_pay_t       pay_s1;
	rhsv_pay_t       front;
	rhsv_pay_t       div_pay [NDIV+1];

	logic [CH_W-1:0] mx;
	logic [CH_W-1:0] mn;
	logic [CH_W-1:0] rng;
	logic [CH_W:0]   diff;
	logic [CH_W-1:0] mag;
	logic [CH_W-1:0] hoff;

	logic [CH_W-1:0] hue_s6;
	logic [CH_W-1:0] sat_s6;
	logic [CH_W-1:0] val_s6;

	// en[0] is stage 1, en[NDIV+1] is the output stage
	always_comb begin
		en[NDIV+1] = !vld_q[NDIV+1] || out_ready;
		for (int i = NDIV; i >= 0; i--) begin
			en[i] = !vld_q[i] || en[i+1];
		end
	end

	assign in_ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int i = 1; i <= NDIV + 1; i++) begin
				if (en[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	always_comb begin
		mx = (red >= green) ? red : green;
		if (blue > mx) begin
			mx = blue;
		end
		mn = (red <= green) ? red : green;
		if (blue < mn) begin
			mn = blue;
		end
		rng = mx - mn;

		front = '0;
		if (red >= green && red >= blue) begin
			front.base = HUE_BASE_RED;
			diff       = {1'b0, green} - {1'b0, blue};
		end else if (green >= blue) begin
			front.base = HUE_BASE_GREEN;
			diff       = {1'b0, blue} - {1'b0, red};
		end else begin
			front.base = HUE_BASE_BLUE;
			diff       = {1'b0, red} - {1'b0, green};
		end
		front.neg = diff[CH_W];
		mag       = diff[CH_W] ? CH_W'(-diff) : diff[CH_W-1:0];

		front.mx      = mx;
		front.rng     = rng;
		front.sat_rem = {rng, {CH_W{1'b0}}} - SAT_REM_W'(rng);
		front.hue_rem = HUE_REM_W'(mag) * HUE_REM_W'(HUE_STEP);
		front.black   = (mx == '0);
		front.grey    = (rng == '0);
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			pay_s1 <= front;
		end
	end

	assign div_pay[0] = pay_s1;

	for (genvar g = 0; g < NDIV; g++) begin : g_div
		rhsv_div_stage #(
			.SAT_TOP (CH_W - 1 - 2 * g),
			.HUE_TOP ((g < NDIV - 1) ? (HUE_Q_W - 1 - 2 * g) : 1),
			.HUE_EN  (g < NDIV - 1)
		) u_stage (
			.clk     (clk),
			.en      (en[g+1]),
			.pay_in  (div_pay[g]),
			.pay_out (div_pay[g+1])
		);
	end

	always_comb begin
		hoff = {{(CH_W-HUE_Q_W){1'b0}}, div_pay[NDIV].hue_q};
		if (div_pay[NDIV].neg) begin
			hoff = -hoff;
		end
	end

	always_ff @(posedge clk) begin
		if (en[NDIV+1]) begin
			hue_s6 <= div_pay[NDIV].grey ? '0 : div_pay[NDIV].base + hoff;
			sat_s6 <= div_pay[NDIV].black ? '0 : div_pay[NDIV].sat_q;
			val_s6 <= div_pay[NDIV].mx;
		end
	end

	assign out_valid  = vld_q[NDIV+1];
	assign hue        = hue_s6;
	assign saturation = sat_s6;
	assign brightness = val_s6;

endmodule

/* rtl/rhsv_div_stage.sv */
`timescale 1ns / 1ps
module rhsv_div_stage import rhsv_pkg::*; #(
	parameter int SAT_TOP = 7,
	parameter int HUE_TOP = 5,
	parameter bit HUE_EN  = 1'b1
) (
	input  logic      clk,
	input  logic      en,
	input  rhsv_pay_t pay_in,
	output rhsv_pay_t pay_out
);

	rhsv_pay_t            nxt;
	rhsv_pay_t            pay_s;
	logic [SAT_REM_W-1:0] sat_rem;
	logic [SAT_REM_W-1:0] sat_try;
	logic [CH_W-1:0]      sat_q;
	logic [HUE_REM_W-1:0] hue_rem;
	logic [HUE_REM_W-1:0] hue_try;
	logic [HUE_Q_W-1:0]   hue_q;

	always_comb begin
		sat_rem = pay_in.sat_rem;
		sat_q   = pay_in.sat_q;
		hue_rem = pay_in.hue_rem;
		hue_q   = pay_in.hue_q;
		sat_try = '0;
		hue_try = '0;
		for (int k = 0; k < 2; k++) begin
			sat_try = SAT_REM_W'(pay_in.mx) << (SAT_TOP - k);
			if (sat_rem >= sat_try) begin
				sat_rem              = sat_rem - sat_try;
				sat_q[SAT_TOP - k]   = 1'b1;
			end
			if (HUE_EN) begin
				hue_try = HUE_REM_W'(pay_in.rng) << (HUE_TOP - k);
				if (hue_rem >= hue_try) begin
					hue_rem            = hue_rem - hue_try;
					hue_q[HUE_TOP - k] = 1'b1;
				end
			end
		end
		nxt         = pay_in;
		nxt.sat_rem = sat_rem;
		nxt.sat_q   = sat_q;
		nxt.hue_rem = hue_rem;
		nxt.hue_q   = hue_q;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_s <= nxt;
		end
	end

	assign pay_out = pay_s;

endmodule

/* rtl/rhsv_checker.sv */
`timescale 1ns / 1ps
module rhsv_checker import rhsv_pkg::*; (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_ready,
	input logic            out_valid,
	input logic            out_ready,
	input logic [CH_W-1:0] hue,
	input logic [CH_W-1:0] saturation,
	input logic [CH_W-1:0] brightness
);

	logic [2:0] cnt_q;
	logic       in_beat;
	logic       out_beat;

	assign in_beat  = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (in_beat && !out_beat) begin
			cnt_q <= cnt_q + 3'd1;
		end else if (out_beat && !in_beat) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hue) && $stable(saturation)
			&& $stable(brightness))
		else $error("stalled output beat changed");

	a_ready_flow: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output drains");

	a_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd6 && (!out_valid || cnt_q != 3'd0))
		else $error("beat count out of bounds");

	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && brightness == '0 |-> hue == '0 && saturation == '0)
		else $error("black pixel with nonzero hue or saturation");

	a_grey: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturation == '0 |-> hue == '0)
		else $error("grey pixel with nonzero hue");

endmodule

bind rgb_to_hsv_8bit rhsv_checker u_rhsv_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.hue        (hue),
	.saturation (saturation),
	.brightness (brightness)
);

/* tb/tb_rgb_to_hsv_8bit.sv */
`timescale 1ns / 1ps
module tb_rgb_to_hsv_8bit;
	import rhsv_pkg::*;

	localparam int N_RANDOM    = 1100;
	localparam int CYCLE_LIMIT = 200000;
	localparam int N_CORNER    = 21;

	typedef struct packed {
		logic [CH_W-1:0] hue;
		logic [CH_W-1:0] sat;
		logic [CH_W-1:0] val;
	} hsv_t;

	typedef struct packed {
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
		bit              known;
		hsv_t            want;
	} corner_row_t;

	logic            clk;
	logic            arst_n     = 1'b0;
	logic            in_valid   = 1'b0;
	logic            in_ready;
	logic [CH_W-1:0] red        = '0;
	logic [CH_W-1:0] green      = '0;
	logic [CH_W-1:0] blue       = '0;
	logic            out_valid;
	logic            out_ready  = 1'b0;
	logic [CH_W-1:0] hue;
	logic [CH_W-1:0] saturation;
	logic [CH_W-1:0] brightness;

	bit   want_known = 1'b0;
	hsv_t want_hsv   = '0;
	bit   calm       = 1'b0;

	hsv_t pending_hsv[$];
	int   n_in     = 0;
	int   n_out    = 0;
	int   n_err    = 0;
	int   n_ties   = 0;
	int   n_greys  = 0;
	int   cycles   = 0;

	corner_row_t corner_rows [N_CORNER] = '{
		'{8'd0,   8'd0,   8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
		'{8'd255, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd0,   8'd255}},
		'{8'd128, 8'd128, 8'd128, 1'b1, '{8'd0,   8'd0,   8'd128}},
		'{8'd1,   8'd1,   8'd1,   1'b1, '{8'd0,   8'd0,   8'd1}},
		'{8'd255, 8'd0,   8'd0,   1'b1, '{8'd0,   8'd255, 8'd255}},
		'{8'd0,   8'd255, 8'd0,   1'b1, '{8'd85,  8'd255, 8'd255}},
		'{8'd0,   8'd0,   8'd255, 1'b1, '{8'd171, 8'd255, 8'd255}},
		'{8'd255, 8'd255, 8'd0,   1'b1, '{8'd43,  8'd255, 8'd255}},
		'{8'd0,   8'd255, 8'd255, 1'b1, '{8'd128, 8'd255, 8'd255}},
		'{8'd255, 8'd0,   8'd255, 1'b1, '{8'd213, 8'd255, 8'd255}},
		'{8'd1,   8'd0,   8'd0,   1'b1, '{8'd0,   8'd255, 8'd1}},
		'{8'd255, 8'd0,   8'd1,   1'b0, '0},
		'{8'd255, 8'd1,   8'd0,   1'b0, '0},
		'{8'd0,   8'd1,   8'd255, 1'b0, '0},
		'{8'd255, 8'd254, 8'd0,   1'b0, '0},
		'{8'd1,   8'd2,   8'd3,   1'b0, '0},
		'{8'd200, 8'd100, 8'd150, 1'b0, '0},
		'{8'd10,  8'd250, 8'd130, 1'b0, '0},
		'{8'd170, 8'd85,  8'd0,   1'b0, '0},
		'{8'd128, 8'd127, 8'd1,   1'b0, '0},
		'{8'd254, 8'd253, 8'd255, 1'b0, '0}
	};

	rgb_to_hsv_8bit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness)
	);

	function automatic hsv_t hsv_of(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
			logic [CH_W-1:0] b);
		int   mx;
		int   mn;
		int   rng;
		int   base;
		int   diff;
		int   h;
		hsv_t p;
		mx = int'((r > g) ? r : g);
		if (b > mx) mx = int'(b);
		mn = int'((r < g) ? r : g);
		if (b < mn) mn = int'(b);
		rng = mx - mn;
		p.val = mx[CH_W-1:0];
		p.sat = '0;
		p.hue = '0;
		if (mx != 0) begin
			p.sat = CH_W'((255 * rng) / mx);
			if (rng != 0) begin
				if (mx == r) begin
					base = int'(HUE_BASE_RED);
					diff = int'(g) - int'(b);
				end else if (mx == g) begin
					base = int'(HUE_BASE_GREEN);
					diff = int'(b) - int'(r);
				end else begin
					base = int'(HUE_BASE_BLUE);
					diff = int'(r) - int'(g);
				end
				h = base + (int'(HUE_STEP) * diff) / rng;
				p.hue = h[CH_W-1:0];
			end
		end
		return p;
	endfunction

	task automatic drive_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
			input logic [CH_W-1:0] b, input bit known, input hsv_t want);
		in_valid   <= 1'b1;
		red        <= r;
		green      <= g;
		blue       <= b;
		want_known <= known;
		want_hsv   <= want;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic maybe_pause();
		if (!calm && $urandom_range(99) < 10) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, pending_hsv.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= calm || ($urandom_range(99) >= 10);
	end

	always @(posedge clk) begin
		hsv_t exp_hsv;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				pending_hsv.push_back(want_known ? want_hsv : hsv_of(red, green, blue));
				n_in++;
			end
			if (out_valid && out_ready) begin
				n_out++;
				if (pending_hsv.size() == 0) begin
					$display("%0t: unexpected beat hue %0d sat %0d val %0d", $time,
						hue, saturation, brightness);
					n_err++;
				end else begin
					exp_hsv = pending_hsv.pop_front();
					if (hue !== exp_hsv.hue) begin
						$display("%0t: hue expected %0d got %0d", $time, exp_hsv.hue, hue);
						n_err++;
					end
					if (saturation !== exp_hsv.sat) begin
						$display("%0t: saturation expected %0d got %0d", $time,
							exp_hsv.sat, saturation);
						n_err++;
					end
					if (brightness !== exp_hsv.val) begin
						$display("%0t: brightness expected %0d got %0d", $time,
							exp_hsv.val, brightness);
						n_err++;
					end
				end
			end
		end
	end

	initial begin
		logic [CH_W-1:0] ch [3];
		logic [CH_W-1:0] top;
		int              mode;
		int              lo_idx;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_CORNER; i++) begin
			maybe_pause();
			drive_pixel(corner_rows[i].r, corner_rows[i].g, corner_rows[i].b,
				corner_rows[i].known, corner_rows[i].want);
		end

		for (int i = 0; i < N_RANDOM; i++) begin
			calm <= (i >= 300 && i < 500);
			if (i == 700) begin
				in_valid <= 1'b0;
				while (pending_hsv.size() != 0) @(posedge clk);
			end
			mode = $urandom_range(9);
			ch[0] = CH_W'($urandom);
			ch[1] = CH_W'($urandom);
			ch[2] = CH_W'($urandom);
			case (mode)
			5: begin
				ch[1] = ch[0];
				ch[2] = ch[0];
				n_greys++;
			end
			6: begin
				top    = CH_W'($urandom_range(255, 1));
				lo_idx = $urandom_range(2);
				for (int k = 0; k < 3; k++)
					ch[k] = (k == lo_idx) ? CH_W'($urandom_range(top - 1)) : top;
				n_ties++;
			end
			7: begin
				for (int k = 0; k < 3; k++)
					ch[k] = CH_W'($urandom_range(3));
			end
			8: ch[$urandom_range(2)] = 8'd255;
			9: ch[$urandom_range(2)] = 8'd0;
			default: ;
			endcase
			maybe_pause();
			drive_pixel(ch[0], ch[1], ch[2], 1'b0, '0);
		end
		in_valid <= 1'b0;
		calm     <= 1'b0;

		while (pending_hsv.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("Summary: %0d pixels in (%0d corner rows, %0d greys, %0d tied maxima),",
			n_in, N_CORNER, n_greys, n_ties);
		$display("         %0d results compared, %0d field mismatches", n_out, n_err);
		if (n_err == 0 && pending_hsv.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
